>>> rtl/iterative_integer_alu_top_assert.svh
// Assertion macros used by the iterative ALU sequencer RTL.
// Each macro expects signals clk and rst_n in the scope that uses it.
`ifndef ITERATIVE_INTEGER_ALU_TOP_ASSERT_SVH
`define ITERATIVE_INTEGER_ALU_TOP_ASSERT_SVH

// Same-cycle implication.
`define IIALU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IIALU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/iialu_pkg.sv
// Package for the iterative integer ALU: widths, opcodes, FSM states and
// the control struct passed from sequencer to datapath. No dependencies.
`timescale 1ns / 1ps

package iialu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int OPC_W      = 3;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  // long ops iterate once per operand bit
  localparam logic [CNT_W-1:0] STEPS_LONG  = CNT_W'(DATA_WIDTH - 1);
  localparam logic [CNT_W-1:0] STEPS_SHORT = '0;

  typedef enum logic [OPC_W-1:0] {
    OPC_ADD = 3'd0,
    OPC_SUB = 3'd1,
    OPC_MUL = 3'd2,
    OPC_DIV = 3'd3,
    OPC_MOD = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_ctrl_t;

endpackage

>>> rtl/iialu_dpath.sv
// Datapath of the iterative ALU: operand, accumulator and flag registers
// around one shared (DATA_WIDTH+1)-bit adder. Depends on iialu_pkg.
`timescale 1ns / 1ps

module iialu_dpath (
  input  logic                                 clk,
  input  iialu_pkg::dp_ctrl_t                  ctl,
  input  logic [iialu_pkg::OPC_W-1:0]          in_opcode,
  input  logic signed [iialu_pkg::DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [iialu_pkg::DATA_WIDTH-1:0] in_operand_b,
  output logic signed [iialu_pkg::DATA_WIDTH-1:0] res_value,
  output logic                                 res_error
);
  import iialu_pkg::*;

  localparam int W = DATA_WIDTH;

  logic [OPC_W-1:0] opc_r;
  logic [W-1:0]     opa_r, opa_nxt;
  logic [W-1:0]     opb_r, opb_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic             err_r, short_r;

  logic [W:0]       add_x, add_y, add_sum;
  logic             add_sub;
  logic             div_op, div_run;

  assign div_op  = (opc_r == OPC_DIV) || (opc_r == OPC_MOD);
  assign div_run = div_op && !err_r && !short_r;

  // shared adder operand selection
  always_comb begin
    add_x   = {1'b0, opa_r};
    add_y   = {1'b0, opb_r};
    add_sub = 1'b0;
    case (opc_r)
      OPC_SUB: add_sub = 1'b1;
      OPC_MUL: begin
        add_x = {1'b0, acc_r};
        add_y = opb_r[0] ? {1'b0, opa_r} : '0;
      end
      OPC_DIV, OPC_MOD: begin
        // restoring division: partial remainder shifted with next dividend bit
        add_x   = {acc_r, opa_r[W-1]};
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {{W{1'b0}}, add_sub};

  always_comb begin
    opa_nxt = opa_r;
    opb_nxt = opb_r;
    acc_nxt = acc_r;
    if (ctl.step) begin
      case (opc_r)
        OPC_ADD, OPC_SUB: acc_nxt = add_sum[W-1:0];
        OPC_MUL: begin
          acc_nxt = add_sum[W-1:0];
          opa_nxt = {opa_r[W-2:0], 1'b0};
          opb_nxt = {1'b0, opb_r[W-1:1]};
        end
        OPC_DIV, OPC_MOD: begin
          if (div_run) begin
            acc_nxt = add_sum[W] ? add_x[W-1:0] : add_sum[W-1:0];
            opa_nxt = {opa_r[W-2:0], ~add_sum[W]};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      opc_r   <= in_opcode;
      opa_r   <= in_operand_a;
      opb_r   <= in_operand_b;
      acc_r   <= '0;
      err_r   <= ((in_opcode == OPC_DIV) || (in_opcode == OPC_MOD))
                 && (in_operand_b <= 0);
      short_r <= in_operand_a < in_operand_b;
    end else begin
      opa_r <= opa_nxt;
      opb_r <= opb_nxt;
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    res_error = 1'b0;
    case (opc_r)
      OPC_ADD, OPC_SUB, OPC_MUL: res_value = acc_r;
      OPC_DIV: begin
        res_error = err_r;
        res_value = (err_r || short_r) ? '0 : opa_r;
      end
      OPC_MOD: begin
        // dividend below divisor: opa_r still holds the untouched dividend
        res_error = err_r;
        res_value = err_r ? '0 : (short_r ? opa_r : acc_r);
      end
      default: res_value = '0;
    endcase
  end

endmodule

>>> rtl/iialu_ctrl.sv
// Sequencer of the iterative ALU: idle/run/done FSM and step counter.
// Depends on iialu_pkg and the assertion macro header.
`timescale 1ns / 1ps

module iialu_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [iialu_pkg::OPC_W-1:0] in_opcode,
  input  logic                        out_free,
  output logic                        in_stall,
  output iialu_pkg::dp_ctrl_t         ctl,
  output logic                        finish
);
  import iialu_pkg::*;
  `include "iterative_integer_alu_top_assert.svh"

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             long_op;

  assign long_op = (in_opcode == OPC_MUL) || (in_opcode == OPC_DIV)
                   || (in_opcode == OPC_MOD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    finish    = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load  = 1'b1;
          cnt_nxt   = long_op ? STEPS_LONG : STEPS_SHORT;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DONE: begin
        // wait here until the output register can take the result
        if (out_free) begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `IIALU_ASSERT_IMP(a_finish_free, finish, out_free, "result pushed into a full output register")
  `IIALU_ASSERT_NXT(a_load_run, ctl.load, state_r == ST_RUN, "load not followed by run")
  `IIALU_ASSERT_NXT(a_last_done, ctl.step && (cnt_r == '0), state_r == ST_DONE && !ctl.step,
                    "iteration did not stop at count zero")

endmodule

>>> rtl/iterative_integer_alu_top.sv
// Top level of the iterative integer ALU: sequencer, datapath and the
// output register. Depends on iialu_pkg, iialu_ctrl and iialu_dpath.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | in_opcode, in_operand_a, in_operand_b
//  out_    | output    | out_valid / out_stall | out_value, out_error
//
// Add, subtract and unused opcodes take a single pass of the shared adder;
// multiply, divide and modulo take one pass per bit of the shared adder loop,
// plus load and writeback. in_stall is high from load until writeback.
// A finished result sits in the output register so a new transaction may
// start while it waits; the core holds its next result if that register is
// still full. rst_n is synchronous, active low, and clears control state only.
`timescale 1ns / 1ps

module iterative_integer_alu_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [iialu_pkg::OPC_W-1:0]             in_opcode,
  input  logic signed [iialu_pkg::DATA_WIDTH-1:0] in_operand_a,
  input  logic signed [iialu_pkg::DATA_WIDTH-1:0] in_operand_b,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [iialu_pkg::DATA_WIDTH-1:0] out_value,
  output logic                                    out_error
);
  import iialu_pkg::*;

  dp_ctrl_t                ctl;
  logic                    finish;
  logic                    out_free;
  logic signed [DATA_WIDTH-1:0] res_value;
  logic                    res_error;

  logic                    out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_value_r;
  logic                    out_error_r;

  assign out_free = !out_valid_r || !out_stall;

  iialu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_opcode(in_opcode),
    .out_free (out_free),
    .in_stall (in_stall),
    .ctl      (ctl),
    .finish   (finish)
  );

  iialu_dpath u_dpath (
    .clk         (clk),
    .ctl         (ctl),
    .in_opcode   (in_opcode),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .res_value   (res_value),
    .res_error   (res_error)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_value_r <= res_value;
      out_error_r <= res_error;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

endmodule
